/* hdl/ppe_pkg.sv */
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared widths, effect codes, register indexes, configuration struct and
// constant tables for the pixel point effect unit.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int CHAN_W      = 8;   // bits per colour channel
  localparam int NUM_CHAN    = 3;   // red, green, blue
  localparam int MODE_W      = 3;
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;   // widest register: max_level

  // Grayscale: divide the channel sum by three through a reciprocal multiply
  localparam int GRAY_SUM_W   = CHAN_W + 2;
  localparam int GRAY_RECIP_W = 10;
  localparam int GRAY_SHIFT   = 11;
  localparam int GRAY_PROD_W  = GRAY_SUM_W + GRAY_RECIP_W;
  localparam logic [GRAY_RECIP_W-1:0] GRAY_RECIP = 10'd683;  // ceil(2^11 / 3)

  // Brighten / darken: c * q / 100 as c * ceil(q * 2^15 / 100) >> 15
  localparam int SCALE_DIV   = 100;
  localparam int SCALE_FRAC  = 15;
  localparam int SCALE_W     = 17;
  localparam int FACTOR_W    = 8;   // q reaches 100 + 127
  localparam int SCALE_ENTRIES = 1 << FACTOR_W;
  localparam int SCALE_PROD_W  = CHAN_W + SCALE_W;
  localparam int WIDE_W        = CHAN_W + 2;  // unclamped result before limiting

  // Sepia: coefficients are the usual ones times 1024
  localparam int SEPIA_FRAC   = 10;
  localparam int SEPIA_COEF_W = 10;
  localparam int SEPIA_ACC_W  = CHAN_W + SEPIA_COEF_W + 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_GRAY     = 3'd0,
    MODE_NEGATIVE = 3'd1,
    MODE_BRIGHTEN = 3'd2,
    MODE_DARKEN   = 3'd3,
    MODE_SEPIA    = 3'd4
  } effect_mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT     = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] effect_mode;
    logic [CHAN_W-1:0] max_level;
    logic [PCT_W-1:0]  percent;
  } ppe_cfg_t;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

  typedef logic [SCALE_W-1:0] scale_tab_t [SCALE_ENTRIES];

  function automatic scale_tab_t build_scale_tab();
    scale_tab_t tab;
    for (int q = 0; q < SCALE_ENTRIES; q++) begin
      tab[q] = SCALE_W'((q * (1 << SCALE_FRAC) + SCALE_DIV - 1) / SCALE_DIV);
    end
    return tab;
  endfunction

  localparam scale_tab_t SCALE_TAB = build_scale_tab();

  localparam logic [SEPIA_COEF_W-1:0] SEPIA_COEF [NUM_CHAN][NUM_CHAN] = '{
    '{10'd402, 10'd787, 10'd194},
    '{10'd357, 10'd702, 10'd172},
    '{10'd279, 10'd547, 10'd134}
  };

endpackage

/* hdl/pixel_point_effect_unit_core.sv */
// ----------------------------------------------------------------------------
// pixel_point_effect_unit_core
// Per-pixel colour effects (gray, negative, brighten, darken, sepia) on an
// RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_* stream, one per transfer, with red in the lowest
//   byte of s_tdata and the frame-end flag on s_tlast. Processed pixels leave
//   on the m_* stream in the same packing, with m_tlast a copy of s_tlast.
//   The effect is set through the write port (cfg_we, cfg_index, cfg_data):
//   index 0 effect mode, 1 maximum level, 2 brightness percent. Write it only
//   while the stream is empty.
//   An accepted pixel is captured in the input register; its result is then
//   loaded into the result register and presented on m_tdata. Throughput:
//   one pixel per clock while m_tready stays high; all arithmetic sits in one
//   combinational pass (one reciprocal multiply for gray, one table-scaled
//   multiply per channel, constant multiplies for sepia) between the two
//   registers.
//   Stall: when m_tready is low the result register holds its pixel and the
//   input register still takes one more pixel; s_tready drops only once
//   both registers are full.
//   Reset (rst, synchronous): both stages empty, mode gray, maximum level
//   255, percent 0.
// ----------------------------------------------------------------------------
module pixel_point_effect_unit_core (
  input  logic                             clk,
  input  logic                             rst,
  // pixel input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // red_in, green_in, blue_in
  input  logic                             s_tlast,   // frame_end_in
  // pixel output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,   // red_out, green_out, blue_out
  output logic                             m_tlast,   // frame_end_out
  // configuration writes
  input  logic                             cfg_we,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ppe_pkg::*;

  ppe_cfg_t cfg;

  // Input stage
  logic   in_valid;
  pixel_t in_pix;
  logic   in_last;

  // Result stage
  logic   out_valid;
  pixel_t out_pix;
  logic   out_last;

  pixel_t calc_pix;
  logic   advance;

  ppe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppe_calc u_calc (
    .cfg     (cfg),
    .pix_in  (in_pix),
    .pix_out (calc_pix)
  );

  // Result register frees up when empty or when its pixel is taken
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  // Capture a new pixel on each input transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pix  <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Load the result when the input stage holds a pixel and the output may move
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_pix  <= calc_pix;
      out_last <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pix;
  assign m_tlast  = out_last;

endmodule

/* hdl/ppe_cfg.sv */
// ----------------------------------------------------------------------------
// ppe_cfg
// Configuration register file: effect mode, maximum level and percent.
// ----------------------------------------------------------------------------
module ppe_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppe_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ppe_pkg::ppe_cfg_t                cfg
);
  import ppe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_mode <= MODE_GRAY;
      cfg.max_level   <= '1;
      cfg.percent     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EFFECT_MODE: cfg.effect_mode <= cfg_data[MODE_W-1:0];
        REG_MAX_LEVEL:   cfg.max_level   <= cfg_data[CHAN_W-1:0];
        REG_PERCENT:     cfg.percent     <= cfg_data[PCT_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

/* hdl/ppe_calc.sv */
// ----------------------------------------------------------------------------
// ppe_calc
// Combinational point operation on one RGB pixel for the selected effect.
// ----------------------------------------------------------------------------
module ppe_calc (
  input  ppe_pkg::ppe_cfg_t cfg,
  input  ppe_pkg::pixel_t   pix_in,
  output ppe_pkg::pixel_t   pix_out
);
  import ppe_pkg::*;

  function automatic logic [CHAN_W-1:0] limit_to(input logic [WIDE_W-1:0] v,
                                                 input logic [CHAN_W-1:0] lim);
    return (v > WIDE_W'(lim)) ? lim : v[CHAN_W-1:0];
  endfunction

  logic [GRAY_SUM_W-1:0]  gray_sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [CHAN_W-1:0]      gray_avg;
  logic [FACTOR_W-1:0]    bright_q;
  logic [FACTOR_W-1:0]    dark_q;
  logic [SCALE_W-1:0]     scale;
  logic [SCALE_PROD_W-1:0] scale_prod [NUM_CHAN];
  logic [WIDE_W-1:0]       scaled     [NUM_CHAN];
  logic [SEPIA_ACC_W-1:0]  sepia_acc  [NUM_CHAN];
  logic [WIDE_W-1:0]       sepia_val  [NUM_CHAN];

  always_comb begin
    gray_sum  = GRAY_SUM_W'(pix_in[0]) + GRAY_SUM_W'(pix_in[1]) + GRAY_SUM_W'(pix_in[2]);
    gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_PROD_W'(GRAY_RECIP);
    gray_avg  = gray_prod[GRAY_SHIFT +: CHAN_W];

    // Darken with percent at or above 100 collapses the factor to zero
    bright_q = FACTOR_W'(SCALE_DIV) + FACTOR_W'(cfg.percent);
    dark_q   = (cfg.percent >= PCT_W'(SCALE_DIV)) ? '0
             : FACTOR_W'(SCALE_DIV) - FACTOR_W'(cfg.percent);
    scale    = SCALE_TAB[(cfg.effect_mode == MODE_DARKEN) ? dark_q : bright_q];

    for (int k = 0; k < NUM_CHAN; k++) begin
      scale_prod[k] = SCALE_PROD_W'(pix_in[k]) * SCALE_PROD_W'(scale);
      scaled[k]     = scale_prod[k][SCALE_FRAC +: WIDE_W];
      sepia_acc[k]  = SEPIA_ACC_W'(SEPIA_COEF[k][0]) * SEPIA_ACC_W'(pix_in[0])
                    + SEPIA_ACC_W'(SEPIA_COEF[k][1]) * SEPIA_ACC_W'(pix_in[1])
                    + SEPIA_ACC_W'(SEPIA_COEF[k][2]) * SEPIA_ACC_W'(pix_in[2]);
      sepia_val[k]  = sepia_acc[k][SEPIA_FRAC +: WIDE_W];
    end

    for (int k = 0; k < NUM_CHAN; k++) begin
      unique case (cfg.effect_mode)
        MODE_GRAY:     pix_out[k] = gray_avg;
        MODE_NEGATIVE: pix_out[k] = (pix_in[k] > cfg.max_level) ? '0
                                  : cfg.max_level - pix_in[k];
        MODE_BRIGHTEN: pix_out[k] = limit_to(scaled[k], cfg.max_level);
        MODE_DARKEN:   pix_out[k] = scaled[k][CHAN_W-1:0];
        MODE_SEPIA:    pix_out[k] = limit_to(sepia_val[k], cfg.max_level);
        default:       pix_out[k] = pix_in[k];  // unused mode: pass through
      endcase
    end
  end

endmodule
